// File: hw/rtl/pilot_mode_and_test_selector_macros.svh
// assertion macros for the pilot mode and test selector
// expects clk and rst in the scope of each use
`ifndef PILOT_MODE_AND_TEST_SELECTOR_MACROS_SVH
`define PILOT_MODE_AND_TEST_SELECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PMTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PMTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PMTS_ASSERT_SAME(label, ante, cons, msg)
`define PMTS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/pmts_pkg.sv
// shared types, codes and constants of the pilot mode and test selector
// no dependencies
package pmts_pkg;

  localparam logic signed [15:0] HALF_Q14     = 16'sd8192;
  localparam logic signed [15:0] NEG_HALF_Q14 = -16'sd8192;

  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_INIT    = 2'd1;
  localparam logic [1:0] MODE_ENGAGE  = 2'd2;

  localparam logic [7:0] PERSIST_MAX      = 8'hFF;
  localparam logic [7:0] THRESHOLD_RESET  = 8'd5;
  localparam logic [7:0] TEST_COUNT_RESET = 8'd19;
  localparam logic [7:0] INDEX_RESET      = 8'd1;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEST_COUNT = 8'd1;

  typedef struct packed {
    logic signed [15:0] mode_sw;
    logic signed [15:0] test_sw;
    logic signed [15:0] trig_sw;
    logic               auto_en;
    logic               fs;
  } pmts_in_t;

  typedef struct packed {
    logic [31:0] frame_counter;
    logic        engaged;
    logic [1:0]  mode;
    logic [7:0]  persist;
    logic        trig_armed;
    logic        arm;
    logic        excite;
    logic [7:0]  index;
  } pmts_state_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic [7:0] test_count;
  } pmts_cfg_t;

endpackage

// File: hw/rtl/pmts_cfg.sv
// configuration registers: trigger persistence threshold and test count
// depends on pmts_pkg
module pmts_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output pmts_pkg::pmts_cfg_t             cfg
);
  import pmts_pkg::*;

  assign cfg_ready = 1'b1;

  // unknown indexes fall through and leave both registers alone
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= THRESHOLD_RESET;
      cfg.test_count <= TEST_COUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD:  cfg.threshold  <= cfg_data;
        REG_TEST_COUNT: cfg.test_count <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/pmts_step.sv
// next-state logic for one frame: mode select, trigger debounce, test index
// depends on pmts_pkg
module pmts_step (
  input  pmts_pkg::pmts_in_t    frame,
  input  pmts_pkg::pmts_state_t st,
  input  pmts_pkg::pmts_cfg_t   cfg,
  output pmts_pkg::pmts_state_t st_next
);
  import pmts_pkg::*;

  logic       fired;
  logic [8:0] idx_up;

  assign idx_up = {1'b0, st.index} + 9'd1;

  always_comb begin
    st_next = st;
    fired   = 1'b0;
    st_next.frame_counter = st.frame_counter + 32'd1;
    if (frame.auto_en && !frame.fs) begin
      st_next.engaged = 1'b1;
      // exactly +0.5 holds mode, arm and excite
      if (frame.mode_sw <= NEG_HALF_Q14) begin
        st_next.mode   = MODE_STANDBY;
        st_next.arm    = 1'b0;
        st_next.excite = 1'b0;
      end else if (frame.mode_sw < HALF_Q14) begin
        st_next.mode   = MODE_INIT;
        st_next.arm    = 1'b0;
        st_next.excite = 1'b0;
      end else if (frame.mode_sw > HALF_Q14) begin
        st_next.mode = MODE_ENGAGE;
        st_next.arm  = 1'b1;
      end

      if (frame.trig_sw > HALF_Q14) begin
        if (st.persist != PERSIST_MAX) st_next.persist = st.persist + 8'd1;
        if (st_next.persist >= cfg.threshold && st.trig_armed) begin
          st_next.trig_armed = 1'b0;
          fired = 1'b1;
        end
      end else begin
        st_next.persist    = 8'd0;
        st_next.trig_armed = 1'b1;
      end

      if (fired) begin
        if (st_next.arm && frame.test_sw > NEG_HALF_Q14 && frame.test_sw < HALF_Q14) begin
          st_next.excite = ~st_next.excite;
        end else if (frame.test_sw <= NEG_HALF_Q14 && !st_next.excite) begin
          st_next.index = (st.index <= 8'd2) ? 8'd1 : st.index - 8'd1;
        end else if (frame.test_sw >= HALF_Q14 && !st_next.excite) begin
          st_next.index = (idx_up >= {1'b0, cfg.test_count}) ? cfg.test_count : idx_up[7:0];
        end
      end else if (frame.test_sw <= NEG_HALF_Q14 || frame.test_sw >= HALF_Q14) begin
        st_next.excite = 1'b0;
      end
    end else begin
      // drop back to reset values; the index is kept and the frame count still steps
      st_next.engaged    = 1'b0;
      st_next.mode       = MODE_STANDBY;
      st_next.persist    = 8'd0;
      st_next.trig_armed = 1'b1;
      st_next.arm        = 1'b0;
      st_next.excite     = 1'b0;
    end
  end

endmodule

// File: hw/rtl/pilot_mode_and_test_selector.sv
// pilot mode and test selector, top level
// data path: an accepted word is held in the input register, then the state/result register drives the outputs
// throughput: one word per cycle; the input register and the state/result register
//   form a two-stage pipe that stalls only when an output word waits to be taken
// reset: synchronous, clears both stages, mode standby, index 1, config to defaults
// depends on pmts_pkg, pmts_cfg, pmts_step and the macros header
`include "pilot_mode_and_test_selector_macros.svh"

module pilot_mode_and_test_selector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               mode_switch,
  input  logic signed [15:0]               test_switch,
  input  logic signed [15:0]               trigger_switch,
  input  logic                             auto_enabled,
  input  logic                             failsafe,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      frame_count,
  output logic                             auto_engaged,
  output logic [1:0]                       control_mode,
  output logic                             test_armed,
  output logic                             test_engaged,
  output logic [7:0]                       test_index,
  output logic [7:0]                       test_total,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data
);
  import pmts_pkg::*;

  pmts_cfg_t   cfg;
  pmts_in_t    s1_word;
  logic        s1_valid;
  logic        s1_advance;
  pmts_state_t st;
  pmts_state_t st_next;

  pmts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state moves only when the result slot is free, so it stays in step with out
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word.mode_sw <= mode_switch;
      s1_word.test_sw <= test_switch;
      s1_word.trig_sw <= trigger_switch;
      s1_word.auto_en <= auto_enabled;
      s1_word.fs      <= failsafe;
    end
  end

  pmts_step u_step (
    .frame   (s1_word),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.frame_counter <= 32'd0;
      st.engaged       <= 1'b0;
      st.mode          <= MODE_STANDBY;
      st.persist       <= 8'd0;
      st.trig_armed    <= 1'b1;
      st.arm           <= 1'b0;
      st.excite        <= 1'b0;
      st.index         <= INDEX_RESET;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // the state register doubles as the result word
  assign frame_count  = st.frame_counter;
  assign auto_engaged = st.engaged;
  assign control_mode = st.mode;
  assign test_armed   = st.arm;
  assign test_engaged = st.excite;
  assign test_index   = st.index;
  assign test_total   = cfg.test_count;

  `PMTS_ASSERT_SAME(a_excite_needs_arm, out_valid && test_engaged, test_armed, "excite without arm")
  `PMTS_ASSERT_SAME(a_disengaged_standby, out_valid && !auto_engaged, control_mode == MODE_STANDBY && !test_armed, "not in standby while disengaged")
  `PMTS_ASSERT_NEXT(a_advance_gives_word, s1_advance, out_valid, "state moved without a result")
  `PMTS_ASSERT_NEXT(a_count_steps, s1_advance, frame_count == $past(frame_count) + 32'd1, "frame count did not step")

endmodule

// File: bench/pmts_frame_check.sv
// frame checker for the pilot mode and test selector: watches the three channels,
// predicts each result word from its own copy of the state and compares
// depends on pmts_pkg
module pmts_frame_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [15:0]               mode_switch,
  input  logic signed [15:0]               test_switch,
  input  logic signed [15:0]               trigger_switch,
  input  logic                             auto_enabled,
  input  logic                             failsafe,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [31:0]                      frame_count,
  input  logic                             auto_engaged,
  input  logic [1:0]                       control_mode,
  input  logic                             test_armed,
  input  logic                             test_engaged,
  input  logic [7:0]                       test_index,
  input  logic [7:0]                       test_total,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [pmts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  output int                               mismatches,
  output int                               pending
);
  import pmts_pkg::*;

  typedef struct packed {
    logic [31:0] frames;
    logic        engaged;
    logic [1:0]  mode;
    logic        armed;
    logic        excited;
    logic [7:0]  index;
    logic [7:0]  total;
  } frame_report_t;

  frame_report_t reports_due[$];

  // predicted selector state
  logic [31:0] frames_seen;
  logic        ctl_engaged;
  logic [1:0]  ctl_mode;
  logic [7:0]  hold_count;
  logic        rearm;
  logic        test_arm;
  logic        excite;
  logic [7:0]  sel_index;
  logic [7:0]  persist_limit;
  logic [7:0]  point_count;

  task automatic clear_controls();
    ctl_engaged = 1'b0;
    ctl_mode = MODE_STANDBY;
    hold_count = 8'd0;
    rearm = 1'b1;
    test_arm = 1'b0;
    excite = 1'b0;
  endtask

  task automatic advance_frame(output frame_report_t rpt);
    logic       fired;
    logic [8:0] step;
    fired = 1'b0;
    frames_seen = frames_seen + 32'd1;
    if (auto_enabled && !failsafe) begin
      ctl_engaged = 1'b1;
      // exactly +0.5 falls through and holds mode, arm and excite
      if (mode_switch <= NEG_HALF_Q14) begin
        ctl_mode = MODE_STANDBY;
        test_arm = 1'b0;
        excite = 1'b0;
      end else if (mode_switch < HALF_Q14) begin
        ctl_mode = MODE_INIT;
        test_arm = 1'b0;
        excite = 1'b0;
      end else if (mode_switch > HALF_Q14) begin
        ctl_mode = MODE_ENGAGE;
        test_arm = 1'b1;
      end
      if (trigger_switch > HALF_Q14) begin
        if (hold_count != PERSIST_MAX) hold_count = hold_count + 8'd1;
        if (hold_count >= persist_limit && rearm) begin
          rearm = 1'b0;
          fired = 1'b1;
        end
      end else begin
        hold_count = 8'd0;
        rearm = 1'b1;
      end
      if (fired) begin
        if (test_arm && test_switch > NEG_HALF_Q14 && test_switch < HALF_Q14) begin
          excite = !excite;
        end else if (test_switch <= NEG_HALF_Q14 && !excite) begin
          sel_index = (sel_index <= 8'd2) ? INDEX_RESET : sel_index - 8'd1;
        end else if (test_switch >= HALF_Q14 && !excite) begin
          step = {1'b0, sel_index} + 9'd1;
          sel_index = (step >= {1'b0, point_count}) ? point_count : step[7:0];
        end
      end else if (test_switch <= NEG_HALF_Q14 || test_switch >= HALF_Q14) begin
        excite = 1'b0;
      end
    end else begin
      clear_controls();
    end
    rpt.frames = frames_seen;
    rpt.engaged = ctl_engaged;
    rpt.mode = ctl_mode;
    rpt.armed = test_arm;
    rpt.excited = excite;
    rpt.index = sel_index;
    rpt.total = point_count;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // sampled at the falling edge, where every channel is settled
  always @(negedge clk) begin
    frame_report_t rpt;
    if (rst) begin
      frames_seen = 32'd0;
      sel_index = INDEX_RESET;
      persist_limit = THRESHOLD_RESET;
      point_count = TEST_COUNT_RESET;
      clear_controls();
      reports_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESHOLD) persist_limit = cfg_data;
        else if (cfg_index == REG_TEST_COUNT) point_count = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $error("result word with no frame waiting: frame_count %0d", frame_count);
          mismatches++;
        end else begin
          rpt = reports_due.pop_front();
          check_field("frame_count", rpt.frames, frame_count);
          check_field("auto_engaged", 32'(rpt.engaged), 32'(auto_engaged));
          check_field("control_mode", 32'(rpt.mode), 32'(control_mode));
          check_field("test_armed", 32'(rpt.armed), 32'(test_armed));
          check_field("test_engaged", 32'(rpt.excited), 32'(test_engaged));
          check_field("test_index", 32'(rpt.index), 32'(test_index));
          check_field("test_total", 32'(rpt.total), 32'(test_total));
        end
      end
      if (in_valid && in_ready) begin
        advance_frame(rpt);
        reports_due.push_back(rpt);
      end
    end
    pending = reports_due.size();
  end

endmodule

// File: bench/testbench.sv
// top of the pilot mode and test selector bench: clock, reset, frame stimulus,
// register phases and the verdict; checking lives in pmts_frame_check
// depends on pmts_pkg, pmts_frame_check and the selector rtl
module testbench;
  import pmts_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_END = REG_TEST_COUNT + 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALL_ONES = '1;

  typedef enum {POS_CENTER, POS_LOW, POS_HIGH} test_pos_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [15:0]     mode_switch = '0;
  logic signed [15:0]     test_switch = '0;
  logic signed [15:0]     trigger_switch = '0;
  logic                   auto_enabled = 1'b0;
  logic                   failsafe = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [31:0]            frame_count;
  logic                   auto_engaged;
  logic [1:0]             control_mode;
  logic                   test_armed;
  logic                   test_engaged;
  logic [7:0]             test_index;
  logic [7:0]             test_total;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;
  int                     mismatches;
  int                     pending;

  int sent = 0;
  int cur_threshold = int'(THRESHOLD_RESET);
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  pilot_mode_and_test_selector uut (.*);
  pmts_frame_check frame_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // result side: a random stall before each word
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  task automatic send_frame(input logic signed [15:0] m, input logic signed [15:0] t,
                            input logic signed [15:0] g, input logic a, input logic f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode_switch <= m;
    test_switch <= t;
    trigger_switch <= g;
    auto_enabled <= a;
    failsafe <= f;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent++;
  endtask

  // hold off until every result word is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] any_switch();
    case ($urandom_range(0, 9))
      0: any_switch = NEG_HALF_Q14;
      1: any_switch = HALF_Q14;
      2: any_switch = $urandom_range(0, 1) ? 16'sd8193 : 16'sd8191;
      3: any_switch = $urandom_range(0, 1) ? -16'sd8193 : -16'sd8191;
      4: any_switch = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: any_switch = 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_mode();
    int v;
    case ($urandom_range(0, 9))
      0: v = ($urandom_range(0, 3) == 0) ? -8192 : -8192 - int'($urandom_range(0, 24576));
      1: v = int'($urandom_range(0, 16382)) - 8191;
      2: v = 8192;
      default: v = 8193 + int'($urandom_range(0, 24574));
    endcase
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] test_position(input test_pos_t where);
    int v;
    case (where)
      POS_CENTER: v = int'($urandom_range(0, 16382)) - 8191;
      POS_LOW: v = ($urandom_range(0, 3) == 0) ? -8192 : -8192 - int'($urandom_range(0, 24576));
      default: v = ($urandom_range(0, 3) == 0) ? 8192 : 8192 + int'($urandom_range(0, 24575));
    endcase
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] trig_pressed();
    return 16'(8193 + int'($urandom_range(0, 24574)));
  endfunction

  function automatic logic signed [15:0] trig_released();
    return ($urandom_range(0, 3) == 0) ? HALF_Q14 : 16'(int'($urandom_range(0, 40960)) - 32768);
  endfunction

  // hold the trigger about as long as the threshold asks, then let go;
  // a broken gesture drops auto or raises failsafe somewhere in the press
  task automatic run_gesture(input bit broken);
    logic signed [15:0] mode_v;
    test_pos_t          where;
    int                 press_len;
    int                 break_at;
    int                 n;
    mode_v = pick_mode();
    where = test_pos_t'($urandom_range(0, 2));
    press_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cur_threshold + 2)
                                            : cur_threshold + $urandom_range(0, 3);
    break_at = broken ? $urandom_range(0, press_len) : -1;
    for (n = 0; n <= press_len; n++) begin
      if ($urandom_range(0, 15) == 0) mode_v = pick_mode();
      if (n == break_at) begin
        if ($urandom_range(0, 1))
          send_frame(mode_v, test_position(where), trig_pressed(), 1'b0, 1'($urandom));
        else
          send_frame(mode_v, test_position(where), trig_pressed(), 1'b1, 1'b1);
      end else if (n < press_len) begin
        send_frame(mode_v, test_position(where), trig_pressed(), 1'b1, 1'b0);
      end
    end
    repeat ($urandom_range(1, 3))
      send_frame(mode_v, test_position(where), trig_released(), 1'b1, 1'b0);
  endtask

  task automatic run_phase(input int thr, input int count, input int items);
    int target;
    int kind;
    drain();
    write_reg(REG_THRESHOLD, 8'(thr));
    write_reg(REG_TEST_COUNT, 8'(count));
    cur_threshold = thr;
    target = sent + items;
    while (sent < target) begin
      no_idle = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        run_gesture(1'b0);
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 8))
          send_frame(any_switch(), any_switch(), any_switch(), 1'($urandom), 1'($urandom));
      end else begin
        run_gesture(1'b1);
      end
      if ($urandom_range(0, 40) == 0) drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: extremes, failsafe, mode bands, a six frame press
    send_frame(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
    send_frame(16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0);
    repeat (6) send_frame(16'sd8193, 16'sd0, 16'sh7FFF, 1'b1, 1'b0);
    send_frame(HALF_Q14, HALF_Q14, 16'sd0, 1'b1, 1'b0);
    send_frame(NEG_HALF_Q14, 16'sd0, 16'sd0, 1'b1, 1'b0);
    send_frame(-16'sd8191, NEG_HALF_Q14, 16'sd0, 1'b1, 1'b0);
    send_frame(16'sd8191, 16'sd0, 16'sd0, 1'b1, 1'b0);

    // writes past the last register must change nothing
    drain();
    write_reg(REG_PAST_END, 8'h00);
    write_reg(REG_ALL_ONES, 8'h00);
    send_frame(16'sd16384, 16'sd0, 16'sd8193, 1'b1, 1'b0);

    // zero threshold: every fresh press fires at once
    drain();
    write_reg(REG_THRESHOLD, 8'd0);
    cur_threshold = 0;
    send_frame(16'sd16384, NEG_HALF_Q14, 16'sd0, 1'b1, 1'b0);
    send_frame(16'sd16384, NEG_HALF_Q14, 16'sd8193, 1'b1, 1'b0);
    send_frame(16'sd16384, HALF_Q14, 16'sd0, 1'b1, 1'b0);
    send_frame(16'sd16384, HALF_Q14, 16'sd8193, 1'b1, 1'b0);
    send_frame(16'sd16384, HALF_Q14, 16'sd8193, 1'b1, 1'b0);
    send_frame(16'sd16384, -16'sd8191, 16'sd0, 1'b1, 1'b0);
    send_frame(16'sd16384, -16'sd8191, 16'sd8193, 1'b1, 1'b0);
    send_frame(16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b0);
    // excited and off center: the index must not step
    send_frame(16'sd16384, NEG_HALF_Q14, 16'sd8193, 1'b1, 1'b0);
    send_frame(16'sd16384, 16'sd8191, 16'sd0, 1'b1, 1'b0);
    send_frame(16'sd0, 16'sd0, 16'sd8193, 1'b1, 1'b0);
    send_frame(HALF_Q14, 16'sd0, 16'sd0, 1'b0, 1'b0);

    run_phase(0, 1, 300);
    run_phase(255, 255, 350);
    run_phase(3, 255, 400);
    run_phase($urandom_range(1, 8), $urandom_range(2, 40), 400);
    run_phase(1, 2, 200);
    run_phase(int'(THRESHOLD_RESET), int'(TEST_COUNT_RESET), 200);

    drain();
    if (mismatches == 0 && pending == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pmts_pkg.sv
hw/rtl/pmts_cfg.sv
hw/rtl/pmts_step.sv
hw/rtl/pilot_mode_and_test_selector.sv
bench/pmts_frame_check.sv
bench/testbench.sv
